// ----- rtl/lpwg_pkg.sv -----
// Shared types and constants for the line pixel write generator.
`timescale 1ns / 1ps
`default_nettype none

package lpwg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int COLOR_W   = 32;
  localparam int BASE_W    = 32;
  localparam int PITCH_W   = 16;
  localparam int BPP_W     = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic OPC_START = 1'b0;
  localparam logic OPC_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 4'd3;

  localparam logic [BASE_W-1:0]  FRAME_BASE_RST = 32'd0;
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST  = 16'd2560;
  localparam logic [BPP_W-1:0]   BPP_RST        = 3'd4;

  // Live configuration; bpp is already folded into 1..4.
  typedef struct packed {
    logic [BASE_W-1:0]  frame_base;
    logic [PITCH_W-1:0] row_pitch;
    logic [BPP_W-1:0]   bpp;
    logic               big_endian;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/lpwg_cfg.sv -----
// Configuration register bank with pixel size folding.
`timescale 1ns / 1ps
`default_nettype none

module lpwg_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lpwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lpwg_pkg::CFG_DATA_W-1:0] cfg_data,
  output lpwg_pkg::cfg_t                      cfg
);
  import lpwg_pkg::*;

  logic [BASE_W-1:0]  frame_base_r;
  logic [PITCH_W-1:0] row_pitch_r;
  logic [BPP_W-1:0]   bpp_r;
  logic               big_endian_r;
  logic [BPP_W-1:0]   bpp_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= FRAME_BASE_RST;
      row_pitch_r  <= ROW_PITCH_RST;
      bpp_r        <= BPP_RST;
      big_endian_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_BASE: frame_base_r <= cfg_data[BASE_W-1:0];
        REG_ROW_PITCH:  row_pitch_r  <= cfg_data[PITCH_W-1:0];
        REG_BPP:        bpp_r        <= cfg_data[BPP_W-1:0];
        REG_BIG_ENDIAN: big_endian_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Treat zero as one byte and anything above four as four.
  always_comb begin
    case (bpp_r) inside
      3'd0:          bpp_eff = 3'd1;
      [3'd5:3'd7]:   bpp_eff = 3'd4;
      default:       bpp_eff = bpp_r;
    endcase
  end

  assign cfg.frame_base = frame_base_r;
  assign cfg.row_pitch  = row_pitch_r;
  assign cfg.bpp        = bpp_eff;
  assign cfg.big_endian = big_endian_r;

endmodule

`default_nettype wire

// ----- rtl/lpwg_fifo.sv -----
// Small register queue used between front, back and result port.
`timescale 1ns / 1ps
`default_nettype none

module lpwg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ----- rtl/lpwg_front.sv -----
// Front end: classify input words and work out line setup for starts.
`timescale 1ns / 1ps
`default_nettype none

module lpwg_front #(
  parameter int COORD_BITS = lpwg_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = lpwg_pkg::ADDR_BITS_DEF,
  parameter int CMD_W      = 1 + 3 * ADDR_BITS + 2 * (COORD_BITS + 1) + lpwg_pkg::COLOR_W
) (
  input  wire logic                          in_opcode,
  input  wire logic [COORD_BITS-1:0]         in_start_x,
  input  wire logic [COORD_BITS-1:0]         in_start_y,
  input  wire logic [COORD_BITS-1:0]         in_end_x,
  input  wire logic [COORD_BITS-1:0]         in_end_y,
  input  wire logic [lpwg_pkg::COLOR_W-1:0]  in_line_color,
  input  wire lpwg_pkg::cfg_t                cfg,
  output logic [CMD_W-1:0]                   cmd_word
);
  import lpwg_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int PROD_W = COORD_BITS + PITCH_W;
  localparam int XOFF_W = COORD_BITS + BPP_W;

  logic                  neg_x, neg_y;
  logic [COORD_BITS-1:0] mag_x, mag_y;
  logic [SPAN_W-1:0]     span_x, span_y;
  logic [ADDR_BITS-1:0]  bpp_a, pitch_a, step_x, step_y;
  logic                  swap;
  logic [SPAN_W-1:0]     major_span, minor_span;
  logic [ADDR_BITS-1:0]  major_step, minor_step, diag_step;
  logic [PROD_W-1:0]     row_off;
  logic [XOFF_W-1:0]     col_off;
  logic [ADDR_BITS-1:0]  start_addr;

  assign neg_x = in_end_x < in_start_x;
  assign neg_y = in_end_y < in_start_y;
  assign mag_x = neg_x ? in_start_x - in_end_x : in_end_x - in_start_x;
  assign mag_y = neg_y ? in_start_y - in_end_y : in_end_y - in_start_y;
  assign span_x = {1'b0, mag_x} + 1'b1;
  assign span_y = {1'b0, mag_y} + 1'b1;

  assign bpp_a   = ADDR_BITS'(cfg.bpp);
  assign pitch_a = ADDR_BITS'(cfg.row_pitch);
  assign step_x  = neg_x ? '0 - bpp_a : bpp_a;
  assign step_y  = neg_y ? '0 - pitch_a : pitch_a;

  // Y leads only when its span is strictly larger.
  assign swap       = span_x < span_y;
  assign major_span = swap ? span_y : span_x;
  assign minor_span = swap ? span_x : span_y;
  assign major_step = swap ? step_y : step_x;
  assign minor_step = swap ? step_x : step_y;
  assign diag_step  = major_step + minor_step;

  assign row_off    = PROD_W'(in_start_y) * PROD_W'(cfg.row_pitch);
  assign col_off    = XOFF_W'(in_start_x) * XOFF_W'(cfg.bpp);
  assign start_addr = ADDR_BITS'(cfg.frame_base) + ADDR_BITS'(row_off)
                    + ADDR_BITS'(col_off);

  assign cmd_word = {in_opcode, start_addr, major_step, diag_step,
                     major_span, minor_span, in_line_color};

endmodule

`default_nettype wire

// ----- rtl/lpwg_back.sv -----
// Back end: hold the line state and emit one pixel write per step word while a line is active.
`timescale 1ns / 1ps
`default_nettype none

module lpwg_back #(
  parameter int COORD_BITS = lpwg_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = lpwg_pkg::ADDR_BITS_DEF,
  parameter int CMD_W      = 1 + 3 * ADDR_BITS + 2 * (COORD_BITS + 1) + lpwg_pkg::COLOR_W,
  parameter int OUT_W      = ADDR_BITS + lpwg_pkg::COLOR_W + lpwg_pkg::BPP_W + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lpwg_pkg::cfg_t   cfg,
  input  wire logic             cmd_empty,
  input  wire logic [CMD_W-1:0] cmd_word,
  output logic                  cmd_pop,
  input  wire logic             out_full,
  output logic                  out_push,
  output logic [OUT_W-1:0]      out_word
);
  import lpwg_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int SUM_W  = COORD_BITS + 2;

  logic                 c_opcode;
  logic [ADDR_BITS-1:0] c_addr, c_major_step, c_diag_step;
  logic [SPAN_W-1:0]    c_major_span, c_minor_span;
  logic [COLOR_W-1:0]   c_color;

  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] major_step_r, diag_step_r;
  logic [SPAN_W-1:0]    major_span_r, minor_span_r;
  logic [SPAN_W-1:0]    err_r, err_nxt;
  logic [SPAN_W-1:0]    done_r;
  logic [COLOR_W-1:0]   color_r;
  logic                 active_r;

  logic [SUM_W-1:0]     err_sum, done_inc;
  logic                 take_diag, is_last, is_step, do_start, do_emit;
  logic [COLOR_W-1:0]   bytes;

  assign {c_opcode, c_addr, c_major_step, c_diag_step,
          c_major_span, c_minor_span, c_color} = cmd_word;

  assign is_step  = (c_opcode == OPC_STEP);
  // A step with no line drains straight away; emitting needs result room.
  assign cmd_pop  = !cmd_empty && (!is_step || !active_r || !out_full);
  assign do_start = cmd_pop && !is_step;
  assign do_emit  = cmd_pop && is_step && active_r;

  assign err_sum   = {1'b0, err_r} + {1'b0, minor_span_r};
  assign take_diag = err_sum >= {1'b0, major_span_r};
  assign err_nxt   = take_diag ? SPAN_W'(err_sum - {1'b0, major_span_r})
                               : SPAN_W'(err_sum);
  assign addr_nxt  = addr_r + (take_diag ? diag_step_r : major_step_r);
  assign done_inc  = {1'b0, done_r} + 1'b1;
  assign is_last   = done_inc >= {1'b0, major_span_r};

  // Place colour bytes in memory order; unused high bytes stay zero.
  always_comb begin
    logic [1:0] src;
    bytes = '0;
    src   = '0;
    for (int i = 0; i < 4; i++) begin
      if (BPP_W'(i) < cfg.bpp) begin
        src = cfg.big_endian ? 2'(cfg.bpp - BPP_W'(1) - BPP_W'(i)) : 2'(i);
        bytes[8*i +: 8] = color_r[{src, 3'b000} +: 8];
      end
    end
  end

  assign out_push = do_emit;
  assign out_word = {addr_r, bytes, cfg.bpp, is_last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (do_start) begin
      active_r <= 1'b1;
    end else if (do_emit && is_last) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      addr_r       <= c_addr;
      major_step_r <= c_major_step;
      diag_step_r  <= c_diag_step;
      major_span_r <= c_major_span;
      minor_span_r <= c_minor_span;
      color_r      <= c_color;
      err_r        <= '0;
      done_r       <= '0;
    end else if (do_emit) begin
      addr_r <= addr_nxt;
      err_r  <= err_nxt;
      done_r <= SPAN_W'(done_inc);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/line_pixel_write_generator_unit.sv -----
// Top level: line rasteriser producing one framebuffer pixel write per step word of an active line.
// A step word passes through the command queue, the back end and the result queue before it can be popped.
// Throughput: one input word per cycle while in_full is low; one pixel write per cycle while pop stays high.
// Start words produce no result; setup math is done on entry, so they are popped without waiting for result room.
// Reset (rst_n low, synchronous): configuration registers to their defaults, both queues empty, no line.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_write_generator_unit #(
  parameter int COORD_BITS = lpwg_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = lpwg_pkg::ADDR_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_opcode,
  input  wire logic [COORD_BITS-1:0]           in_start_x,
  input  wire logic [COORD_BITS-1:0]           in_start_y,
  input  wire logic [COORD_BITS-1:0]           in_end_x,
  input  wire logic [COORD_BITS-1:0]           in_end_y,
  input  wire logic [lpwg_pkg::COLOR_W-1:0]    in_line_color,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [ADDR_BITS-1:0]                 out_write_address,
  output logic [lpwg_pkg::COLOR_W-1:0]         out_write_bytes,
  output logic [lpwg_pkg::BPP_W-1:0]           out_byte_count,
  output logic                                 out_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpwg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpwg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpwg_pkg::*;

  localparam int CMD_W = 1 + 3 * ADDR_BITS + 2 * (COORD_BITS + 1) + COLOR_W;
  localparam int OUT_W = ADDR_BITS + COLOR_W + BPP_W + 1;

  cfg_t             cfg;
  logic [CMD_W-1:0] cmd_wr_word, cmd_rd_word;
  logic             cmd_empty, cmd_pop;
  logic [OUT_W-1:0] out_wr_word, out_rd_word;
  logic             out_full, out_push;

  lpwg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpwg_front #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .in_opcode     (in_opcode),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_color (in_line_color),
    .cfg           (cfg),
    .cmd_word      (cmd_wr_word)
  );

  lpwg_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (cmd_wr_word),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd_word),
    .empty   (cmd_empty)
  );

  lpwg_back #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS),
    .CMD_W      (CMD_W),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd_word  (cmd_rd_word),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_word  (out_wr_word)
  );

  lpwg_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (out_push),
    .wr_data (out_wr_word),
    .full    (out_full),
    .pop     (out_pop),
    .rd_data (out_rd_word),
    .empty   (out_empty)
  );

  assign {out_write_address, out_write_bytes, out_byte_count, out_last} = out_rd_word;

endmodule

`default_nettype wire
